### rtl/core/sstk_pkg.sv
// ----------------------------------------------------------------------------
// Sortable stack package
// Shared constants, action codes and sequencer states of the sortable stack.
// ----------------------------------------------------------------------------
package sstk_pkg;

  localparam int DEPTH_DEF = 32;
  localparam int VALUE_W   = 32;
  localparam int ACTION_W  = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH  = 2'd0,
    ACT_POP   = 2'd1,
    ACT_SORT  = 2'd2,
    ACT_PRINT = 2'd3
  } sstk_action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EMIT,
    ST_SORT_RD0,
    ST_SORT_LD,
    ST_SORT_CMP,
    ST_SORT_END,
    ST_PR_RD,
    ST_PR_OUT
  } sstk_state_t;

endpackage

### rtl/core/sstk_if.sv
// ----------------------------------------------------------------------------
// Sortable stack channels
// Request and response channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface sstk_req_if;
  import sstk_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [ACTION_W-1:0]        action;
  logic signed [VALUE_W-1:0]  push_value;

  modport source (output valid, output action, output push_value, input ready);
  modport sink   (input valid, input action, input push_value, output ready);
endinterface

interface sstk_rsp_if;
  import sstk_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [VALUE_W-1:0]  item_value;
  logic                       list_empty;
  logic                       overflow;
  logic                       last;

  modport source (output valid, output item_value, output list_empty, output overflow,
                  output last, input ready);
  modport sink   (input valid, input item_value, input list_empty, input overflow,
                  input last, output ready);
endinterface

### rtl/core/sortable_stack_with_dump.sv
// ----------------------------------------------------------------------------
// Sortable stack with dump
// Bounded LIFO of signed values with push, pop, in-place sort and print.
//
//   Channel  Direction  Payload
//   req      in         action, push_value
//   rsp      out        item_value, list_empty, overflow, last
//
// Push and pop complete in the idle state; a dropped push or an empty print
// passes through the emit state. A print of n entries makes one memory read
// and one response transfer per entry. A sort of n entries runs n-1 bubble
// passes through one compare unit and one memory read port. A stalled
// response holds the sequencer; rst clears the count and the sequencer, not
// the stored values.
// ----------------------------------------------------------------------------
module sortable_stack_with_dump #(
  parameter int DEPTH = sstk_pkg::DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  sstk_req_if.sink  req,
  sstk_rsp_if.source rsp
);
  import sstk_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic signed [VALUE_W-1:0] mem [DEPTH];

  sstk_state_t               state, state_next;
  logic [CW-1:0]             count, count_next;
  logic [AW-1:0]             lim, lim_next;
  logic [AW-1:0]             idx, idx_next;
  logic signed [VALUE_W-1:0] hold, hold_next;
  logic                      emit_empty, emit_empty_next;

  logic                      wr_en;
  logic [AW-1:0]             wr_addr;
  logic signed [VALUE_W-1:0] wr_data;
  logic                      rd_en;
  logic [AW-1:0]             rd_addr;
  logic signed [VALUE_W-1:0] rd_data;

  logic                      out_valid;
  logic signed [VALUE_W-1:0] out_value;
  logic                      out_empty;
  logic                      out_ovf;
  logic                      out_last;
  logic                      load_out;
  logic signed [VALUE_W-1:0] load_value;
  logic                      load_empty;
  logic                      load_ovf;
  logic                      load_last;

  logic                      out_free;
  logic [CW-1:0]             cnt_m1;
  logic                      rd_larger;

  assign out_free  = !out_valid || rsp.ready;
  assign cnt_m1    = count - CW'(1);
  assign rd_larger = rd_data > hold;
  assign req.ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    lim        <= lim_next;
    idx        <= idx_next;
    hold       <= hold_next;
    emit_empty <= emit_empty_next;
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    lim_next        = lim;
    idx_next        = idx;
    hold_next       = hold;
    emit_empty_next = emit_empty;
    wr_en           = 1'b0;
    wr_addr         = idx;
    wr_data         = hold;
    rd_en           = 1'b0;
    rd_addr         = idx;
    load_out        = 1'b0;
    load_value      = '0;
    load_empty      = 1'b0;
    load_ovf        = 1'b0;
    load_last       = 1'b1;

    case (state)
      ST_IDLE: begin
        if (req.valid) begin
          case (sstk_action_t'(req.action))
            ACT_PUSH: begin
              if (count == CW'(DEPTH)) begin
                emit_empty_next = 1'b0;
                state_next      = ST_EMIT;
              end else begin
                wr_en      = 1'b1;
                wr_addr    = count[AW-1:0];
                wr_data    = req.push_value;
                count_next = count + CW'(1);
              end
            end
            ACT_POP: begin
              if (count != '0) begin
                count_next = cnt_m1;
              end
            end
            ACT_SORT: begin
              if (count > CW'(1)) begin
                lim_next   = cnt_m1[AW-1:0];
                state_next = ST_SORT_RD0;
              end
            end
            ACT_PRINT: begin
              if (count == '0) begin
                emit_empty_next = 1'b1;
                state_next      = ST_EMIT;
              end else begin
                idx_next   = cnt_m1[AW-1:0];
                state_next = ST_PR_RD;
              end
            end
            default: begin
              state_next = ST_IDLE;
            end
          endcase
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          load_out   = 1'b1;
          load_empty = emit_empty;
          load_ovf   = !emit_empty;
          state_next = ST_IDLE;
        end
      end

      ST_SORT_RD0: begin
        rd_en      = 1'b1;
        rd_addr    = '0;
        state_next = ST_SORT_LD;
      end

      ST_SORT_LD: begin
        hold_next  = rd_data;
        rd_en      = 1'b1;
        rd_addr    = AW'(1);
        idx_next   = AW'(1);
        state_next = ST_SORT_CMP;
      end

      // The smaller value rides upward toward the front of the stack.
      ST_SORT_CMP: begin
        wr_en     = 1'b1;
        wr_addr   = idx - AW'(1);
        wr_data   = rd_larger ? rd_data : hold;
        hold_next = rd_larger ? hold : rd_data;
        if (idx == lim) begin
          state_next = ST_SORT_END;
        end else begin
          rd_en    = 1'b1;
          rd_addr  = idx + AW'(1);
          idx_next = idx + AW'(1);
        end
      end

      ST_SORT_END: begin
        wr_en   = 1'b1;
        wr_addr = lim;
        wr_data = hold;
        if (lim == AW'(1)) begin
          state_next = ST_IDLE;
        end else begin
          lim_next   = lim - AW'(1);
          state_next = ST_SORT_RD0;
        end
      end

      ST_PR_RD: begin
        rd_en      = 1'b1;
        rd_addr    = idx;
        state_next = ST_PR_OUT;
      end

      ST_PR_OUT: begin
        if (out_free) begin
          load_out   = 1'b1;
          load_value = rd_data;
          load_last  = (idx == '0);
          if (idx == '0) begin
            state_next = ST_IDLE;
          end else begin
            idx_next   = idx - AW'(1);
            state_next = ST_PR_RD;
          end
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_value <= load_value;
      out_empty <= load_empty;
      out_ovf   <= load_ovf;
      out_last  <= load_last;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.item_value = out_value;
  assign rsp.list_empty = out_empty;
  assign rsp.overflow   = out_ovf;
  assign rsp.last       = out_last;

endmodule

### rtl/core/sstk_checker.sv
// ----------------------------------------------------------------------------
// Sortable stack checker
// Port-level properties of the sortable stack, bound to the top level.
// ----------------------------------------------------------------------------
module sstk_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                req_valid,
  input logic                                req_ready,
  input logic [sstk_pkg::ACTION_W-1:0]       req_action,
  input logic                                rsp_valid,
  input logic                                rsp_ready,
  input logic signed [sstk_pkg::VALUE_W-1:0] rsp_item_value,
  input logic                                rsp_list_empty,
  input logic                                rsp_overflow,
  input logic                                rsp_last
);
  import sstk_pkg::*;

  // A stalled response keeps its item value and last flag.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item_value) && $stable(rsp_last))
    else $error("stalled response changed");

  // Empty and overflow reports never appear together.
  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp_list_empty && rsp_overflow))
    else $error("empty and overflow both set");

  // An empty or overflow report is a single zero-valued final transfer.
  a_flag_single: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_list_empty || rsp_overflow) |-> rsp_last && rsp_item_value == '0)
    else $error("flagged response malformed");

  // A print always occupies the sequencer for at least the next cycle.
  a_print_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_action == ACT_PRINT |=> !req_ready)
    else $error("ready right after a print transfer");

endmodule

bind sortable_stack_with_dump sstk_checker u_sstk_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .req_action     (req.action),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_item_value (rsp.item_value),
  .rsp_list_empty (rsp.list_empty),
  .rsp_overflow   (rsp.overflow),
  .rsp_last       (rsp.last)
);

### tb/sv/sstk_check_pkg.sv
// ----------------------------------------------------------------------------
// Sortable stack scoreboard
// Mirrors the stack contents and holds the response items that the
// accepted requests are due to produce, then checks each response transfer.
// ----------------------------------------------------------------------------
package sstk_check_pkg;
  import sstk_pkg::*;

  typedef struct packed {
    logic signed [VALUE_W-1:0] item_value;
    logic                      list_empty;
    logic                      overflow;
    logic                      last;
  } stack_item_t;

  class stack_mirror;
    // Index 0 holds the back of the stack, the highest index the front.
    logic signed [VALUE_W-1:0] entries[$];
    stack_item_t               awaited[$];
    int                        depth;
    int                        mismatches;

    function new(int depth_limit);
      depth      = depth_limit;
      mismatches = 0;
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    function stack_item_t make_item(logic signed [VALUE_W-1:0] value, logic empty,
                                    logic ovf, logic fin);
      stack_item_t item;
      item.item_value = value;
      item.list_empty = empty;
      item.overflow   = ovf;
      item.last       = fin;
      return item;
    endfunction

    function void sort_entries();
      int                        i;
      int                        j;
      logic signed [VALUE_W-1:0] key;
      for (i = 1; i < entries.size(); i++) begin
        key = entries[i];
        j   = i;
        while (j > 0 && entries[j-1] < key) begin
          entries[j] = entries[j-1];
          j--;
        end
        entries[j] = key;
      end
    endfunction

    function void note_request(sstk_action_t act, logic signed [VALUE_W-1:0] value);
      int i;
      case (act)
        ACT_PUSH: begin
          if (entries.size() >= depth) begin
            awaited.push_back(make_item('0, 1'b0, 1'b1, 1'b1));
          end else begin
            entries.push_back(value);
          end
        end
        ACT_POP: begin
          if (entries.size() > 0) begin
            void'(entries.pop_back());
          end
        end
        ACT_SORT: begin
          sort_entries();
        end
        default: begin
          if (entries.size() == 0) begin
            awaited.push_back(make_item('0, 1'b1, 1'b0, 1'b1));
          end else begin
            for (i = entries.size() - 1; i >= 0; i--) begin
              awaited.push_back(make_item(entries[i], 1'b0, 1'b0, i == 0));
            end
          end
        end
      endcase
    endfunction

    task check_item(stack_item_t got);
      stack_item_t exp;
      if (awaited.size() == 0) begin
        report_mismatch($sformatf("unexpected response value %0d empty %b ovf %b last %b",
                                  got.item_value, got.list_empty, got.overflow, got.last));
      end else begin
        exp = awaited[0];
        awaited.delete(0);
        if (got.item_value !== exp.item_value) begin
          report_mismatch($sformatf("item_value got %0d expected %0d",
                                    got.item_value, exp.item_value));
        end
        if (got.list_empty !== exp.list_empty) begin
          report_mismatch($sformatf("list_empty got %b expected %b",
                                    got.list_empty, exp.list_empty));
        end
        if (got.overflow !== exp.overflow) begin
          report_mismatch($sformatf("overflow got %b expected %b",
                                    got.overflow, exp.overflow));
        end
        if (got.last !== exp.last) begin
          report_mismatch($sformatf("last got %b expected %b", got.last, exp.last));
        end
      end
    endtask

    task flag_leftovers();
      if (awaited.size() != 0) begin
        report_mismatch($sformatf("%0d response items never arrived", awaited.size()));
      end
    endtask
  endclass

endpackage

### tb/sv/tb_sortable_stack_with_dump.sv
// ----------------------------------------------------------------------------
// Sortable stack with dump testbench
// Drives push, pop, sort and print requests with random gaps and response
// stalls, mirrors the stack contents and checks every response transfer.
// ----------------------------------------------------------------------------
module tb_sortable_stack_with_dump;
  timeunit 1ns;
  timeprecision 1ps;

  import sstk_pkg::*;
  import sstk_check_pkg::*;

  localparam int ITEM_TARGET     = 470;
  localparam int RSP_HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES   = 800;
  localparam int WATCHDOG_LIMIT  = 8000;

  localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

  logic clk = 1'b0;
  logic rst = 1'b1;

  sstk_req_if req_ch ();
  sstk_rsp_if rsp_ch ();

  sortable_stack_with_dump #(
    .DEPTH(DEPTH_DEF)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  stack_mirror book;
  stack_item_t got_item;
  int          items_sent  = 0;
  int          stack_level = 0;
  int          req_calm    = 0;
  int          rsp_calm    = 0;
  int          idle_cycles = 0;
  bit          hold_rsp    = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int draw_gap(inout int calm);
    int gap;
    if (calm > 0) begin
      calm--;
      gap = 0;
    end else if ($urandom_range(0, 19) == 0) begin
      calm = $urandom_range(10, 30);
      gap  = 0;
    end else begin
      gap = $urandom_range(0, 12);
    end
    return gap;
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_value();
    logic signed [VALUE_W-1:0] v;
    case ($urandom_range(0, 5))
      0:       v = VAL_MIN;
      1:       v = VAL_MAX;
      2, 3:    v = $urandom_range(0, 15) - 8;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic send_action(input sstk_action_t act, input logic signed [VALUE_W-1:0] value);
    int gap;
    gap = draw_gap(req_calm);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.action     <= act;
    req_ch.push_value <= value;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    if (act == ACT_PUSH && stack_level < DEPTH_DEF) begin
      stack_level++;
    end else if (act == ACT_POP && stack_level > 0) begin
      stack_level--;
    end
    items_sent++;
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (book.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic fill_stack();
    while (stack_level < DEPTH_DEF) send_action(ACT_PUSH, pick_value());
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
        got_item.item_value = rsp_ch.item_value;
        got_item.list_empty = rsp_ch.list_empty;
        got_item.overflow   = rsp_ch.overflow;
        got_item.last       = rsp_ch.last;
        book.check_item(got_item);
      end
      if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) begin
        book.note_request(sstk_action_t'(req_ch.action), req_ch.push_value);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
        (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : rsp_side
    int gap;
    rsp_ch.ready <= 1'b0;
    forever begin
      if (hold_rsp) begin
        hold_rsp = 1'b0;
        gap      = RSP_HOLD_CYCLES;
      end else begin
        gap = draw_gap(rsp_calm);
      end
      if (gap > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!(rsp_ch.valid === 1'b1 && !rst));
    end
  end

  initial begin : req_side
    int  kind;
    int  len;
    int  r;
    bit  pressure_done;
    book              = new(DEPTH_DEF);
    pressure_done     = 1'b0;
    req_ch.valid      <= 1'b0;
    req_ch.action     <= ACT_PUSH;
    req_ch.push_value <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_action(ACT_PRINT, pick_value());
    send_action(ACT_POP, pick_value());
    send_action(ACT_SORT, pick_value());
    send_action(ACT_PUSH, VAL_MIN);
    send_action(ACT_SORT, VAL_MAX);
    send_action(ACT_PRINT, '0);
    send_action(ACT_PUSH, VAL_MAX);
    send_action(ACT_PUSH, '0);
    send_action(ACT_PUSH, -1);
    send_action(ACT_PUSH, 1);
    send_action(ACT_PUSH, 32'h5555_5555);
    send_action(ACT_PUSH, 32'hAAAA_AAAA);
    send_action(ACT_PUSH, 1);
    send_action(ACT_PRINT, VAL_MIN);
    send_action(ACT_SORT, '0);
    send_action(ACT_PRINT, -1);
    send_action(ACT_POP, '0);
    send_action(ACT_PRINT, '0);
    send_action(ACT_POP, '0);
    send_action(ACT_SORT, '0);
    send_action(ACT_PRINT, '0);
    fill_stack();
    send_action(ACT_PUSH, VAL_MAX);
    send_action(ACT_PRINT, '0);
    wait_drained();

    while (items_sent < ITEM_TARGET) begin
      if (!pressure_done && items_sent >= 200) begin
        pressure_done = 1'b1;
        hold_rsp      = 1'b1;
        send_action(ACT_PRINT, pick_value());
        fill_stack();
        repeat (4) send_action(ACT_PRINT, pick_value());
        send_action(ACT_PUSH, pick_value());
        wait_drained();
      end
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1: begin
          fill_stack();
          repeat ($urandom_range(1, 3)) send_action(ACT_PUSH, pick_value());
          if ($urandom_range(0, 1) == 1) send_action(ACT_SORT, pick_value());
          send_action(ACT_PRINT, pick_value());
        end
        2: begin
          len = stack_level + $urandom_range(1, 3);
          repeat (len) send_action(ACT_POP, pick_value());
          send_action(ACT_PRINT, pick_value());
        end
        8: begin
          send_action(ACT_SORT, pick_value());
          send_action(ACT_PRINT, pick_value());
          repeat ($urandom_range(1, 4)) send_action(ACT_PUSH, pick_value());
          send_action(ACT_SORT, pick_value());
          send_action(ACT_PRINT, pick_value());
        end
        9: begin
          repeat ($urandom_range(4, 10)) begin
            send_action(sstk_action_t'($urandom_range(0, 3)), $urandom);
          end
        end
        default: begin
          len = $urandom_range(8, 20);
          repeat (len) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
              send_action(ACT_PUSH, pick_value());
            end else if (r < 70) begin
              send_action(ACT_POP, pick_value());
            end else if (r < 85) begin
              send_action(ACT_SORT, pick_value());
            end else begin
              send_action(ACT_PRINT, pick_value());
            end
          end
        end
      endcase
    end

    wait_drained();
    book.flag_leftovers();
    if (book.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
